>>> hw/rtl/bsft_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Subscription fanout table package
// Shared constants, status codes and types for the subscriber table block.
// ----------------------------------------------------------------------------
package bsft_pkg;

  localparam int BUS_COUNT_DEF     = 16;
  localparam int SLOTS_PER_BUS_DEF = 32;
  localparam int CONN_ID_BITS_DEF  = 8;

  localparam int MODE_W   = 2;
  localparam int BUS_W    = 8;
  localparam int CONN_W   = 8;
  localparam int START_W  = 6;
  localparam int STATUS_W = 3;
  localparam int SLOT_W   = 6;
  localparam int FOUND_W  = 8;

  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 24;

  localparam logic [MODE_W-1:0] MODE_ADD      = 2'd0;
  localparam int                MODE_NEXT_BIT = 1;

  localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] ST_BAD_BUS   = 3'd1;
  localparam logic [STATUS_W-1:0] ST_BAD_CONN  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd3;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd4;
  localparam logic [STATUS_W-1:0] ST_END       = 3'd5;

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_REMOVE = 2'd1,
    OP_NEXT   = 2'd2
  } op_t;

  typedef enum logic [3:0] {
    S_CLEAR = 4'b0001,
    S_IDLE  = 4'b0010,
    S_SCAN  = 4'b0100,
    S_DONE  = 4'b1000
  } state_t;

endpackage

>>> hw/rtl/bus_subscription_fanout_table_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bus subscription fanout table
// Per-bus subscriber slots with add, remove and next-recipient lookup.
// ----------------------------------------------------------------------------
// Each request on the in_ channel is one operation (add, remove or next) on
// one bus; each request yields exactly one result on the out_ channel.
// The table sits in one memory, and a single comparator walks the slots of
// the addressed bus one per cycle through the registered read port.
// A request that fails its connection or bus check, or a next request that
// starts past the last slot, goes from idle straight to the done state and
// is not scanned. A scan ends at the first matching slot or at the last
// slot of the bus, and the done state then loads the result register.
// in_tready is high only while the block is idle; one request is in work
// at a time, and the next request can be accepted in the cycle after the
// previous result is loaded. The result register lets a new request be
// accepted while the previous result still waits; a stalled receiver holds
// a finished scan in its last step until the result register frees.
// After reset a clearing pass writes zero to all BUS_COUNT * SLOTS_PER_BUS
// entries, one per cycle, before the first request is accepted.
// ----------------------------------------------------------------------------
module bus_subscription_fanout_table_core #(
  parameter int BUS_COUNT     = bsft_pkg::BUS_COUNT_DEF,
  parameter int SLOTS_PER_BUS = bsft_pkg::SLOTS_PER_BUS_DEF,
  parameter int CONN_ID_BITS  = bsft_pkg::CONN_ID_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // mode[1:0], bus[9:2], conn_id[17:10], start_slot[23:18]
  input  logic [bsft_pkg::IN_DATA_W-1:0]  in_tdata,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // status[2:0], slot[8:3], found_conn[16:9], zero[23:17]
  output logic [bsft_pkg::OUT_DATA_W-1:0] out_tdata
);

  localparam int DEPTH  = BUS_COUNT * SLOTS_PER_BUS;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int IDX_W  = $clog2(SLOTS_PER_BUS + 1);

  logic [bsft_pkg::MODE_W-1:0]  in_mode;
  logic [bsft_pkg::BUS_W-1:0]   in_bus;
  logic [bsft_pkg::CONN_W-1:0]  in_conn_id;
  logic [bsft_pkg::START_W-1:0] in_start_slot;

  assign in_mode       = in_tdata[1:0];
  assign in_bus        = in_tdata[9:2];
  assign in_conn_id    = in_tdata[17:10];
  assign in_start_slot = in_tdata[23:18];

  bsft_pkg::state_t state_r, state_nxt;
  bsft_pkg::op_t    op_r, op_nxt;

  logic [ADDR_W-1:0]       clr_addr_r, clr_addr_nxt;
  logic [CONN_ID_BITS-1:0] conn_r, conn_nxt;
  logic [ADDR_W-1:0]       base_r, base_nxt;
  logic [IDX_W-1:0]        rd_idx_r, rd_idx_nxt;
  logic [IDX_W-1:0]        cmp_idx_r, cmp_idx_nxt;
  logic                    cmp_vld_r, cmp_vld_nxt;

  logic [bsft_pkg::STATUS_W-1:0] res_status_r, res_status_nxt;
  logic [bsft_pkg::SLOT_W-1:0]   res_slot_r, res_slot_nxt;
  logic [bsft_pkg::FOUND_W-1:0]  res_found_r, res_found_nxt;

  logic                          out_vld_r, out_vld_nxt;
  logic [bsft_pkg::STATUS_W-1:0] out_status_r, out_status_nxt;
  logic [bsft_pkg::SLOT_W-1:0]   out_slot_r, out_slot_nxt;
  logic [bsft_pkg::FOUND_W-1:0]  out_found_r, out_found_nxt;

  logic                    mem_we;
  logic [ADDR_W-1:0]       mem_waddr;
  logic [CONN_ID_BITS-1:0] mem_wdata;
  logic                    mem_re;
  logic [CONN_ID_BITS-1:0] mem_rdata;

  logic conn_bad;
  logic bus_bad;
  logic start_past;
  logic issue;
  logic hit;
  logic last_slot;

  bsft_table #(
    .DATA_W (CONN_ID_BITS),
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W)
  ) u_table (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (mem_waddr),
    .wr_data (mem_wdata),
    .rd_en   (mem_re),
    .rd_addr (base_r + ADDR_W'(rd_idx_r)),
    .rd_data (mem_rdata)
  );

  assign in_tready = (state_r == bsft_pkg::S_IDLE);

  assign conn_bad   = (in_conn_id == '0) ||
                      ((32'(in_conn_id) >> CONN_ID_BITS) != 32'd0);
  assign bus_bad    = (in_bus == '0) || (32'(in_bus) > 32'(BUS_COUNT));
  assign start_past = 32'(in_start_slot) >= 32'(SLOTS_PER_BUS);

  assign issue     = 32'(rd_idx_r) < 32'(SLOTS_PER_BUS);
  assign last_slot = 32'(cmp_idx_r) == 32'(SLOTS_PER_BUS - 1);

  always_comb begin
    case (op_r)
      bsft_pkg::OP_ADD:    hit = (mem_rdata == '0);
      bsft_pkg::OP_REMOVE: hit = (mem_rdata == conn_r);
      bsft_pkg::OP_NEXT:   hit = (mem_rdata != '0) && (mem_rdata != conn_r);
      default:             hit = 1'b0;
    endcase
  end

  always_comb begin
    state_nxt      = state_r;
    op_nxt         = op_r;
    clr_addr_nxt   = clr_addr_r;
    conn_nxt       = conn_r;
    base_nxt       = base_r;
    rd_idx_nxt     = rd_idx_r;
    cmp_idx_nxt    = cmp_idx_r;
    cmp_vld_nxt    = cmp_vld_r;
    res_status_nxt = res_status_r;
    res_slot_nxt   = res_slot_r;
    res_found_nxt  = res_found_r;
    out_vld_nxt    = out_vld_r && !out_tready;
    out_status_nxt = out_status_r;
    out_slot_nxt   = out_slot_r;
    out_found_nxt  = out_found_r;
    mem_we         = 1'b0;
    mem_waddr      = clr_addr_r;
    mem_wdata      = '0;
    mem_re         = 1'b0;

    case (state_r)
      bsft_pkg::S_CLEAR: begin
        mem_we       = 1'b1;
        clr_addr_nxt = clr_addr_r + 1'b1;
        if (clr_addr_r == ADDR_W'(DEPTH - 1)) begin
          state_nxt = bsft_pkg::S_IDLE;
        end
      end
      bsft_pkg::S_IDLE: begin
        if (in_tvalid) begin
          if (in_mode[bsft_pkg::MODE_NEXT_BIT]) begin
            op_nxt = bsft_pkg::OP_NEXT;
          end else if (in_mode == bsft_pkg::MODE_ADD) begin
            op_nxt = bsft_pkg::OP_ADD;
          end else begin
            op_nxt = bsft_pkg::OP_REMOVE;
          end
          conn_nxt      = CONN_ID_BITS'(in_conn_id);
          base_nxt      = ADDR_W'((32'(in_bus) - 32'd1) * 32'(SLOTS_PER_BUS));
          rd_idx_nxt    = '0;
          cmp_vld_nxt   = 1'b0;
          res_slot_nxt  = '0;
          res_found_nxt = '0;
          if (in_mode[bsft_pkg::MODE_NEXT_BIT] && !start_past) begin
            rd_idx_nxt = IDX_W'(in_start_slot);
          end
          if (conn_bad) begin
            res_status_nxt = bsft_pkg::ST_BAD_CONN;
            state_nxt      = bsft_pkg::S_DONE;
          end else if (bus_bad) begin
            res_status_nxt = bsft_pkg::ST_BAD_BUS;
            state_nxt      = bsft_pkg::S_DONE;
          end else if (in_mode[bsft_pkg::MODE_NEXT_BIT] && start_past) begin
            res_status_nxt = bsft_pkg::ST_END;
            state_nxt      = bsft_pkg::S_DONE;
          end else begin
            state_nxt = bsft_pkg::S_SCAN;
          end
        end
      end
      bsft_pkg::S_SCAN: begin
        mem_re      = issue;
        cmp_vld_nxt = issue;
        cmp_idx_nxt = rd_idx_r;
        if (issue) begin
          rd_idx_nxt = rd_idx_r + 1'b1;
        end
        if (cmp_vld_r) begin
          if (hit) begin
            res_status_nxt = bsft_pkg::ST_OK;
            res_slot_nxt   = bsft_pkg::SLOT_W'(32'(cmp_idx_r) + 32'd1);
            res_found_nxt  = '0;
            mem_waddr      = base_r + ADDR_W'(cmp_idx_r);
            case (op_r)
              bsft_pkg::OP_ADD: begin
                mem_we    = 1'b1;
                mem_wdata = conn_r;
              end
              bsft_pkg::OP_REMOVE: begin
                mem_we    = 1'b1;
                mem_wdata = '0;
              end
              default: begin
                res_found_nxt = bsft_pkg::FOUND_W'(mem_rdata);
              end
            endcase
            cmp_vld_nxt = 1'b0;
            state_nxt   = bsft_pkg::S_DONE;
          end else if (last_slot) begin
            case (op_r)
              bsft_pkg::OP_ADD:    res_status_nxt = bsft_pkg::ST_FULL;
              bsft_pkg::OP_REMOVE: res_status_nxt = bsft_pkg::ST_NOT_FOUND;
              default:             res_status_nxt = bsft_pkg::ST_END;
            endcase
            res_slot_nxt  = '0;
            res_found_nxt = '0;
            cmp_vld_nxt   = 1'b0;
            state_nxt     = bsft_pkg::S_DONE;
          end
        end
      end
      bsft_pkg::S_DONE: begin
        if (!out_vld_r || out_tready) begin
          out_vld_nxt    = 1'b1;
          out_status_nxt = res_status_r;
          out_slot_nxt   = res_slot_r;
          out_found_nxt  = res_found_r;
          state_nxt      = bsft_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = bsft_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= bsft_pkg::S_CLEAR;
      clr_addr_r <= '0;
      cmp_vld_r  <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      clr_addr_r <= clr_addr_nxt;
      cmp_vld_r  <= cmp_vld_nxt;
      out_vld_r  <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    conn_r       <= conn_nxt;
    base_r       <= base_nxt;
    rd_idx_r     <= rd_idx_nxt;
    cmp_idx_r    <= cmp_idx_nxt;
    res_status_r <= res_status_nxt;
    res_slot_r   <= res_slot_nxt;
    res_found_r  <= res_found_nxt;
    out_status_r <= out_status_nxt;
    out_slot_r   <= out_slot_nxt;
    out_found_r  <= out_found_nxt;
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {7'd0, out_found_r, out_slot_r, out_status_r};

endmodule

>>> hw/rtl/bsft_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Subscriber table memory
// One write port and one registered read port over the flat slot array.
// ----------------------------------------------------------------------------
module bsft_table #(
  parameter int DATA_W = bsft_pkg::CONN_ID_BITS_DEF,
  parameter int DEPTH  = bsft_pkg::BUS_COUNT_DEF * bsft_pkg::SLOTS_PER_BUS_DEF,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [DATA_W-1:0] wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

>>> sim/tb_bus_subscription_fanout_table_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Subscription fanout table testbench
// Drives add, remove and next-recipient requests into the subscriber table
// and checks every result against a cycle-free model of the per-bus slots
module tb_bus_subscription_fanout_table_core;
  import bsft_pkg::*;

  localparam int                CLK_HALF      = 10;
  localparam int                CYCLE_LIMIT   = 1000000;
  localparam int                RANDOM_ITEMS  = 1700;
  localparam int                DRAIN_CYCLES  = 2 * SLOTS_PER_BUS_DEF + 16;
  localparam int                IDLE_PCT      = 27;
  localparam logic [MODE_W-1:0] MODE_NEXT_ALT = 2'd3;

  typedef struct packed {
    logic [MODE_W-1:0]  mode;
    logic [BUS_W-1:0]   bus;
    logic [CONN_W-1:0]  conn;
    logic [START_W-1:0] start;
  } fanout_req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   slot;
    logic [FOUND_W-1:0]  found;
  } fanout_res_t;

  typedef struct packed {
    fanout_req_t req;
    logic        typed;
    fanout_res_t res;
  } stim_row_t;

  localparam int DIR_N = 22;
  localparam stim_row_t DIR_ROWS [DIR_N] = '{
    '{'{OP_NEXT,       8'd1,   8'd1,   6'd0},  1'b1, '{ST_END,       6'd0, 8'd0}},
    '{'{OP_REMOVE,     8'd1,   8'd5,   6'd0},  1'b1, '{ST_NOT_FOUND, 6'd0, 8'd0}},
    '{'{OP_ADD,        8'd1,   8'd5,   6'd0},  1'b1, '{ST_OK,        6'd1, 8'd0}},
    '{'{OP_ADD,        8'd1,   8'd5,   6'd0},  1'b1, '{ST_OK,        6'd2, 8'd0}},
    '{'{OP_ADD,        8'd16,  8'd255, 6'd0},  1'b1, '{ST_OK,        6'd1, 8'd0}},
    '{'{OP_ADD,        8'd0,   8'd7,   6'd0},  1'b1, '{ST_BAD_BUS,   6'd0, 8'd0}},
    '{'{OP_ADD,        8'd17,  8'd7,   6'd0},  1'b1, '{ST_BAD_BUS,   6'd0, 8'd0}},
    '{'{OP_ADD,        8'd255, 8'd0,   6'd0},  1'b1, '{ST_BAD_CONN,  6'd0, 8'd0}},
    '{'{OP_NEXT,       8'd1,   8'd0,   6'd0},  1'b1, '{ST_BAD_CONN,  6'd0, 8'd0}},
    '{'{OP_REMOVE,     8'd255, 8'd9,   6'd63}, 1'b1, '{ST_BAD_BUS,   6'd0, 8'd0}},
    '{'{OP_NEXT,       8'd1,   8'd5,   6'd0},  1'b1, '{ST_END,       6'd0, 8'd0}},
    '{'{OP_ADD,        8'd1,   8'd9,   6'd0},  1'b0, '{ST_OK,        6'd0, 8'd0}},
    '{'{OP_NEXT,       8'd1,   8'd5,   6'd0},  1'b0, '{ST_OK,        6'd0, 8'd0}},
    '{'{MODE_NEXT_ALT, 8'd1,   8'd1,   6'd0},  1'b0, '{ST_OK,        6'd0, 8'd0}},
    '{'{OP_NEXT,       8'd1,   8'd1,   6'd32}, 1'b1, '{ST_END,       6'd0, 8'd0}},
    '{'{OP_NEXT,       8'd1,   8'd1,   6'd63}, 1'b1, '{ST_END,       6'd0, 8'd0}},
    '{'{OP_NEXT,       8'd1,   8'd1,   6'd31}, 1'b0, '{ST_OK,        6'd0, 8'd0}},
    '{'{OP_REMOVE,     8'd1,   8'd5,   6'd0},  1'b0, '{ST_OK,        6'd0, 8'd0}},
    '{'{OP_ADD,        8'd1,   8'd170, 6'd0},  1'b0, '{ST_OK,        6'd0, 8'd0}},
    '{'{OP_NEXT,       8'd16,  8'd1,   6'd0},  1'b0, '{ST_OK,        6'd0, 8'd0}},
    '{'{OP_REMOVE,     8'd16,  8'd255, 6'd0},  1'b0, '{ST_OK,        6'd0, 8'd0}},
    '{'{OP_NEXT,       8'd16,  8'd254, 6'd0},  1'b0, '{ST_OK,        6'd0, 8'd0}}
  };

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  // mode[1:0], bus[9:2], conn_id[17:10], start_slot[23:18]
  logic [IN_DATA_W-1:0]  in_tdata   = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  // status[2:0], slot[8:3], found_conn[16:9], zero[23:17]
  logic [OUT_DATA_W-1:0] out_tdata;

  logic [CONN_W-1:0] subs_tbl [BUS_COUNT_DEF][SLOTS_PER_BUS_DEF];
  fanout_res_t       pending_results [$];
  fanout_res_t       want_res;
  fanout_res_t       got_res;
  int                mismatches  = 0;
  int                cycle_count = 0;
  bit                no_idle     = 1'b0;

  bus_subscription_fanout_table_core uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    clk = 1'b0;
    #CLK_HALF;
    clk = 1'b1;
    #CLK_HALF;
  end

  function automatic fanout_res_t apply_subscription(fanout_req_t r);
    fanout_res_t res;
    int          row;
    int          s;
    bit          hit;
    res = '0;
    hit = 1'b0;
    row = int'(r.bus) - 1;
    if (r.conn == '0 || int'(r.conn) >= (1 << CONN_ID_BITS_DEF)) begin
      res.status = ST_BAD_CONN;
    end else if (r.bus == '0 || int'(r.bus) > BUS_COUNT_DEF) begin
      res.status = ST_BAD_BUS;
    end else if (r.mode[MODE_NEXT_BIT]) begin
      for (s = int'(r.start) + 1; s <= SLOTS_PER_BUS_DEF && !hit; s++) begin
        if (subs_tbl[row][s-1] != '0 && subs_tbl[row][s-1] != r.conn) begin
          hit        = 1'b1;
          res.status = ST_OK;
          res.slot   = SLOT_W'(s);
          res.found  = subs_tbl[row][s-1];
        end
      end
      if (!hit) res.status = ST_END;
    end else if (r.mode == OP_ADD) begin
      for (s = 1; s <= SLOTS_PER_BUS_DEF && !hit; s++) begin
        if (subs_tbl[row][s-1] == '0) begin
          hit              = 1'b1;
          subs_tbl[row][s-1] = r.conn;
          res.status       = ST_OK;
          res.slot         = SLOT_W'(s);
        end
      end
      if (!hit) res.status = ST_FULL;
    end else begin
      for (s = 1; s <= SLOTS_PER_BUS_DEF && !hit; s++) begin
        if (subs_tbl[row][s-1] == r.conn) begin
          hit              = 1'b1;
          subs_tbl[row][s-1] = '0;
          res.status       = ST_OK;
          res.slot         = SLOT_W'(s);
        end
      end
      if (!hit) res.status = ST_NOT_FOUND;
    end
    return res;
  endfunction

  // Early requests favor adds so buses fill up; requests 1100 to 1399 favor removes.
  function automatic fanout_req_t random_request(int idx);
    fanout_req_t r;
    int          add_pct;
    int          rem_pct;
    int          roll;
    if (idx < 400) begin
      add_pct = 65;
      rem_pct = 10;
    end else if (idx >= 1100 && idx < 1400) begin
      add_pct = 15;
      rem_pct = 60;
    end else begin
      add_pct = 35;
      rem_pct = 30;
    end
    roll = $urandom_range(0, 99);
    if (roll < add_pct) r.mode = OP_ADD;
    else if (roll < add_pct + rem_pct) r.mode = OP_REMOVE;
    else if ($urandom_range(0, 4) == 0) r.mode = MODE_NEXT_ALT;
    else r.mode = OP_NEXT;
    case ($urandom_range(0, 9))
      0: r.bus = BUS_W'($urandom_range(1, BUS_COUNT_DEF));
      1: r.bus = BUS_W'(BUS_COUNT_DEF);
      default: r.bus = BUS_W'($urandom_range(1, 3));
    endcase
    if ($urandom_range(0, 4) == 0) r.conn = CONN_W'($urandom_range(1, 255));
    else r.conn = CONN_W'($urandom_range(1, 6));
    roll = $urandom_range(0, 9);
    if (roll < 4) r.start = '0;
    else if (roll < 9) r.start = START_W'($urandom_range(0, SLOTS_PER_BUS_DEF));
    else r.start = START_W'($urandom_range(0, 63));
    roll = $urandom_range(0, 99);
    if (roll < 3) r.conn = '0;
    else if (roll < 5) r.bus = '0;
    else if (roll < 7) r.bus = BUS_W'($urandom_range(BUS_COUNT_DEF + 1, 255));
    return r;
  endfunction

  task automatic send_request(fanout_req_t r, logic typed, fanout_res_t typed_res);
    fanout_res_t pred;
    while (!no_idle && $urandom_range(0, 99) < IDLE_PCT) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {r.start, r.conn, r.bus, r.mode};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pred = apply_subscription(r);
    pending_results.push_back(typed ? typed_res : pred);
  endtask

  task automatic wait_all_results();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic report_mismatch(string what, int got, int want);
    if (mismatches < 50) begin
      $display("mismatch: %s got %0d expected %0d", what, got, want);
    end
    mismatches++;
  endtask

  always @(posedge clk) begin
    out_tready <= no_idle || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      got_res = '{out_tdata[2:0], out_tdata[8:3], out_tdata[16:9]};
      if (pending_results.size() == 0) begin
        report_mismatch("result with no request outstanding, status", got_res.status, 0);
      end else begin
        want_res = pending_results.pop_front();
        if (got_res.status != want_res.status)
          report_mismatch("status", got_res.status, want_res.status);
        if (got_res.slot != want_res.slot)
          report_mismatch("slot", got_res.slot, want_res.slot);
        if (got_res.found != want_res.found)
          report_mismatch("found_conn", got_res.found, want_res.found);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_bus_subscription_fanout_table_core NOT OK");
      $finish;
    end
  end

  initial begin
    for (int b = 0; b < BUS_COUNT_DEF; b++) begin
      for (int s = 0; s < SLOTS_PER_BUS_DEF; s++) subs_tbl[b][s] = '0;
    end
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    for (int i = 0; i < DIR_N; i++) begin
      send_request(DIR_ROWS[i].req, DIR_ROWS[i].typed, DIR_ROWS[i].res);
    end
    wait_all_results();
    @(posedge clk);
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      no_idle = (i >= 800 && i < 1100);
      if (i == 700) wait_all_results();
      send_request(random_request(i), 1'b0, '0);
    end
    no_idle = 1'b0;
    wait_all_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb_bus_subscription_fanout_table_core OK");
    end else begin
      $display("tb_bus_subscription_fanout_table_core NOT OK");
    end
    $finish;
  end

endmodule
